// ----- rtl/core/tdfa_pkg.sv -----
// shared types and constants for the table-driven dfa acceptor
`default_nettype none

package tdfa_pkg;

    localparam int STATE_W  = 6;
    localparam int SYMBOL_W = 8;
    localparam int ACTION_W = 2;
    localparam int CAUSE_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int ENTRY_W  = STATE_W + 1;

    localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_MARK   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FEED   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_FINISH = 2'd3;

    localparam logic [CAUSE_W-1:0] CAUSE_NONE      = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_MISSING   = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_DEAD      = 2'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_NONACCEPT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_START     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_USED = 2'd2;

    localparam logic [STATE_W-1:0] START_RESET = 6'd0;
    localparam logic [STATE_W-1:0] DEAD_RESET  = 6'd63;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } ctrl_state_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic mark;
        logic feed_issue;
        logic feed_apply;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/tdfa_ctrl.sv -----
// controller state machine: table clearing, request dispatch, lookup sequencing
`default_nettype none

module tdfa_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [tdfa_pkg::ACTION_W-1:0] action,
    input  wire tdfa_pkg::dp_status_t          status,
    output tdfa_pkg::dp_cmd_t                  cmd,
    output logic                               busy
);
    import tdfa_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign take = start && (state_reg == ST_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (take && action == ACT_FEED)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy            = 1'b1;
        cmd             = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            ST_IDLE:
            begin
                busy           = 1'b0;
                cmd.load       = take && action == ACT_LOAD;
                cmd.mark       = take && action == ACT_MARK;
                cmd.feed_issue = take && action == ACT_FEED;
                cmd.finish     = take && action == ACT_FINISH;
            end
            ST_LOOKUP:
            begin
                cmd.feed_apply = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/tdfa_datapath.sv -----
// datapath: transition memory, accepting flags, walk state, config and result registers
`default_nettype none

module tdfa_datapath #(
    parameter int NUM_STATES  = 64,
    parameter int NUM_SYMBOLS = 256
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire tdfa_pkg::dp_cmd_t              cmd,
    output tdfa_pkg::dp_status_t                status,
    input  wire logic [tdfa_pkg::SYMBOL_W-1:0]  symbol,
    input  wire logic [tdfa_pkg::STATE_W-1:0]   src_state,
    input  wire logic [tdfa_pkg::STATE_W-1:0]   dst_state,
    input  wire logic [tdfa_pkg::STATE_W-1:0]   marked_state,
    input  wire logic                           cfg_we,
    input  wire logic [tdfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tdfa_pkg::STATE_W-1:0]   cfg_data,
    output logic                                done,
    output logic                                accepted,
    output logic [tdfa_pkg::STATE_W-1:0]        end_state,
    output logic [tdfa_pkg::CAUSE_W-1:0]        reject_cause
);
    import tdfa_pkg::*;

    localparam int ST_BITS   = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam int SIDX_W    = (ST_BITS < STATE_W) ? ST_BITS : STATE_W;
    localparam int SYM_IDX_W = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int ADDR_W    = SIDX_W + SYM_IDX_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int FLAG_N    = 1 << SIDX_W;
    localparam int CMP_ST_W  = 11;
    localparam int CMP_SYM_W = SYMBOL_W + 1;
    localparam logic [CMP_ST_W-1:0]  NUM_STATES_L  = CMP_ST_W'(NUM_STATES);
    localparam logic [CMP_SYM_W-1:0] NUM_SYMBOLS_L = CMP_SYM_W'(NUM_SYMBOLS);

    logic [ENTRY_W-1:0] mem [MEM_DEPTH];

    logic [ADDR_W-1:0]  clr_addr_reg;
    logic [ADDR_W-1:0]  clr_addr_next;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               lookup_ok_reg;
    logic               lookup_ok_next;
    logic [FLAG_N-1:0]  flags_reg;
    logic [FLAG_N-1:0]  flags_next;
    logic [STATE_W-1:0] cur_reg;
    logic [STATE_W-1:0] cur_next;
    logic [CAUSE_W-1:0] rej_reg;
    logic [CAUSE_W-1:0] rej_next;
    logic [STATE_W-1:0] start_reg;
    logic [STATE_W-1:0] start_next;
    logic [STATE_W-1:0] dead_reg;
    logic [STATE_W-1:0] dead_next;
    logic               dead_used_reg;
    logic               dead_used_next;
    logic               done_reg;
    logic               accepted_reg;
    logic [STATE_W-1:0] end_state_reg;
    logic [CAUSE_W-1:0] cause_reg;

    logic               sym_ok;
    logic               from_ok;
    logic               to_ok;
    logic               mark_ok;
    logic               cur_ok;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [ADDR_W-1:0]  rd_addr;
    logic [STATE_W-1:0] target;
    logic               fin_acc;
    logic [CAUSE_W-1:0] fin_cause;

    assign sym_ok  = CMP_SYM_W'(symbol) < NUM_SYMBOLS_L;
    assign from_ok = CMP_ST_W'(src_state) < NUM_STATES_L;
    assign to_ok   = CMP_ST_W'(dst_state) < NUM_STATES_L;
    assign mark_ok = CMP_ST_W'(marked_state) < NUM_STATES_L;
    assign cur_ok  = CMP_ST_W'(cur_reg) < NUM_STATES_L;

    assign status.clear_last = (clr_addr_reg == ADDR_W'(MEM_DEPTH - 1));
    assign clr_addr_next     = cmd.clear ? clr_addr_reg + ADDR_W'(1) : clr_addr_reg;

    // single write port shared by clearing pass and transition loads
    assign wr_en   = cmd.clear || (cmd.load && from_ok && sym_ok && to_ok);
    assign wr_addr = cmd.clear ? clr_addr_reg
                               : {src_state[SIDX_W-1:0], symbol[SYM_IDX_W-1:0]};
    assign wr_data = cmd.clear ? '0 : {1'b1, dst_state};
    assign rd_addr = {cur_reg[SIDX_W-1:0], symbol[SYM_IDX_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.feed_issue)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign lookup_ok_next = cmd.feed_issue ? (cur_ok && sym_ok) : lookup_ok_reg;
    assign target         = rd_data_reg[STATE_W-1:0];

    always_comb
    begin
        flags_next = flags_reg;
        if (cmd.mark && mark_ok)
        begin
            flags_next[marked_state[SIDX_W-1:0]] = 1'b1;
        end
    end

    always_comb
    begin
        fin_acc   = 1'b0;
        fin_cause = rej_reg;
        if (rej_reg == CAUSE_NONE)
        begin
            if (cur_ok && flags_reg[cur_reg[SIDX_W-1:0]])
            begin
                fin_acc = 1'b1;
            end
            else
            begin
                fin_cause = CAUSE_NONACCEPT;
            end
        end
    end

    always_comb
    begin
        cur_next       = cur_reg;
        rej_next       = rej_reg;
        start_next     = start_reg;
        dead_next      = dead_reg;
        dead_used_next = dead_used_reg;
        if (cmd.feed_apply && rej_reg == CAUSE_NONE)
        begin
            if (!lookup_ok_reg || !rd_data_reg[ENTRY_W-1])
            begin
                rej_next = CAUSE_MISSING;
            end
            else
            begin
                cur_next = target;
                if (dead_used_reg && target == dead_reg)
                begin
                    rej_next = CAUSE_DEAD;
                end
            end
        end
        if (cmd.finish)
        begin
            cur_next = start_reg;
            rej_next = CAUSE_NONE;
        end
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_START:
                begin
                    start_next = cfg_data;
                    cur_next   = cfg_data;
                    rej_next   = CAUSE_NONE;
                end
                CFG_DEAD:
                begin
                    dead_next = cfg_data;
                end
                CFG_DEAD_USED:
                begin
                    dead_used_next = cfg_data[0];
                end
                default:
                begin
                    dead_used_next = dead_used_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            lookup_ok_reg <= 1'b0;
            flags_reg     <= '0;
            cur_reg       <= START_RESET;
            rej_reg       <= CAUSE_NONE;
            start_reg     <= START_RESET;
            dead_reg      <= DEAD_RESET;
            dead_used_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            clr_addr_reg  <= clr_addr_next;
            lookup_ok_reg <= lookup_ok_next;
            flags_reg     <= flags_next;
            cur_reg       <= cur_next;
            rej_reg       <= rej_next;
            start_reg     <= start_next;
            dead_reg      <= dead_next;
            dead_used_reg <= dead_used_next;
            done_reg      <= cmd.finish;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            accepted_reg  <= fin_acc;
            end_state_reg <= cur_reg;
            cause_reg     <= fin_cause;
        end
    end

    assign done         = done_reg;
    assign accepted     = accepted_reg;
    assign end_state    = end_state_reg;
    assign reject_cause = cause_reg;

endmodule

`default_nettype wire

// ----- rtl/core/table_driven_dfa_acceptor_core.sv -----
// top level of the table-driven dfa acceptor
//
// requests enter on start/busy with action, symbol, src_state, dst_state and
// marked_state; a request is taken at a clock edge with start high and busy low.
// load, mark and finish leave busy low; a feed raises busy for a lookup state, since the
// next-state memory read is registered and the walk state updates from it.
// a finish gives one result: done is high for exactly one cycle, the cycle after
// the request is taken, with accepted, end_state and reject_cause valid in it.
// the receiver has no back-pressure; results are never held.
// configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. index 0 start state, 1 dead state, 2 dead state enable.
// writing the start state also restarts the string in progress.
// after reset the next-state memory is cleared one entry per cycle, with busy
// high until all 2^(clog2(NUM_STATES)+clog2(NUM_SYMBOLS)) entries (16384 by default) are cleared;
// configuration writes are taken during that pass.
`default_nettype none

module table_driven_dfa_acceptor_core #(
    parameter int NUM_STATES  = 64,
    parameter int NUM_SYMBOLS = 256
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [tdfa_pkg::ACTION_W-1:0]  action,
    input  wire logic [tdfa_pkg::SYMBOL_W-1:0]  symbol,
    input  wire logic [tdfa_pkg::STATE_W-1:0]   src_state,
    input  wire logic [tdfa_pkg::STATE_W-1:0]   dst_state,
    input  wire logic [tdfa_pkg::STATE_W-1:0]   marked_state,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tdfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tdfa_pkg::STATE_W-1:0]   cfg_data,
    output logic                                done,
    output logic                                accepted,
    output logic [tdfa_pkg::STATE_W-1:0]        end_state,
    output logic [tdfa_pkg::CAUSE_W-1:0]        reject_cause
);
    import tdfa_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    tdfa_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    tdfa_datapath #(
        .NUM_STATES  (NUM_STATES),
        .NUM_SYMBOLS (NUM_SYMBOLS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .symbol       (symbol),
        .src_state    (src_state),
        .dst_state    (dst_state),
        .marked_state (marked_state),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .accepted     (accepted),
        .end_state    (end_state),
        .reject_cause (reject_cause)
    );

endmodule

`default_nettype wire

// ----- rtl/core/tdfa_props.sv -----
// port-level assertions for the dfa acceptor, bound to the top level
`default_nettype none

module tdfa_props (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic [tdfa_pkg::ACTION_W-1:0] action,
    input wire logic                          done,
    input wire logic                          accepted,
    input wire logic [tdfa_pkg::CAUSE_W-1:0]  reject_cause
);
    import tdfa_pkg::*;

    // a result only follows a finish request taken in the cycle before
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && action == ACT_FINISH))
    else $error("result without finish request");

    // every finish request gives a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == ACT_FINISH) |=> done)
    else $error("finish request lost");

    // accept flag agrees with the cause code
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (accepted == (reject_cause == CAUSE_NONE)))
    else $error("accepted and reject_cause disagree");

    // a symbol request holds off the next request for the lookup cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == ACT_FEED) |=> busy)
    else $error("no lookup cycle after symbol request");

    // load, mark and finish leave the block ready
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action != ACT_FEED) |=> !busy)
    else $error("busy after single-cycle request");

endmodule

bind table_driven_dfa_acceptor_core tdfa_props u_props (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .done         (done),
    .accepted     (accepted),
    .reject_cause (reject_cause)
);

`default_nettype wire
